>>> design/chacha20_stream_xor_unit_macros.svh
// Assertion helpers for the stream cipher unit.
// Each macro expects clk and arst_n in scope.
`ifndef CHACHA20_STREAM_XOR_UNIT_MACROS_SVH
`define CHACHA20_STREAM_XOR_UNIT_MACROS_SVH

// Same-cycle implication
`define CXS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CXS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cxs_pkg.sv
`default_nettype none
package cxs_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int QUEUE_DEPTH_DEF   = 4;
	localparam int STATE_WORDS       = 16;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA [4] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_KEY_LOW   = 3'd0,
		CFG_KEY_MID   = 3'd1,
		CFG_KEY_UPPER = 3'd2,
		CFG_KEY_TOP   = 3'd3,
		CFG_NONCE     = 3'd4
	} cxs_cfg_idx_t;

	// one add-xor-rotate step of the quarter round
	typedef enum logic [1:0] {
		QR_AD16 = 2'd0,
		QR_CB12 = 2'd1,
		QR_AD8  = 2'd2,
		QR_CB7  = 2'd3
	} cxs_qr_step_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROUND,
		BK_FEED,
		BK_EMIT
	} cxs_bk_state_t;

	// queued word, tagged with its keystream position
	typedef struct packed {
		logic [5:0] pos;
		logic [7:0] data;
		logic       last;
		logic       new_block;
	} cxs_item_t;

	typedef struct packed {
		logic      valid;
		cxs_item_t item;
	} cxs_head_t;

	typedef struct packed {
		logic full;
		logic pos_zero;
	} cxs_fr_stat_t;

	typedef struct packed {
		logic emit;
		logic ctr_zero;
	} cxs_bk_stat_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

endpackage
`default_nettype wire

>>> design/cxs_front.sv
`default_nettype none
module cxs_front #(
	parameter int QUEUE_DEPTH = cxs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	input  wire logic               pop,
	output cxs_pkg::cxs_head_t      head,
	output cxs_pkg::cxs_fr_stat_t   stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cxs_pkg::cxs_item_t q_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [5:0]         pos_q;
	logic               full;
	logic               push;
	cxs_pkg::cxs_item_t new_item;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push = in_valid && !full;

	// tag each word with its position; position zero starts a block
	always_comb begin
		new_item.pos       = pos_q;
		new_item.data      = data_byte;
		new_item.last      = last_byte;
		new_item.new_block = (pos_q == 6'd0);
	end

	// track position across the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= last_byte ? 6'd0 : pos_q + 6'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid    = (count_q != '0);
	assign head.item     = q_mem[rd_ptr_q];
	assign stat.full     = full;
	assign stat.pos_zero = (pos_q == 6'd0);

endmodule
`default_nettype wire

>>> design/cxs_back.sv
`default_nettype none
module cxs_back #(
	parameter int DOUBLE_ROUNDS = cxs_pkg::DOUBLE_ROUNDS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cxs_pkg::cxs_head_t head,
	input  wire logic [3:0][63:0]   key,
	input  wire logic [63:0]        nonce,
	input  wire logic               out_stall,
	output logic                    pop,
	output logic                    out_valid,
	output logic [7:0]              out_byte,
	output logic                    out_last,
	output cxs_pkg::cxs_bk_stat_t   stat
);

	localparam int DR_W = $clog2(DOUBLE_ROUNDS);
	localparam int NW   = cxs_pkg::STATE_WORDS;

	cxs_pkg::cxs_bk_state_t state_q, state_d;
	cxs_pkg::cxs_qr_step_t  step_q;
	logic                   half_q;
	logic [DR_W-1:0]        dr_q;
	logic [63:0]            counter_q;
	logic [31:0]            w_q    [NW];
	logic [31:0]            init_w [NW];
	logic [31:0]            nw     [NW];
	logic [31:0]            pw     [NW];
	logic                   load_w;
	logic                   round_en;
	logic                   feed_en;
	logic                   emit;
	logic                   out_free;
	logic                   last_step;
	logic [31:0]            ks_word;
	logic [7:0]             ks_byte;
	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic                   out_last_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = (step_q == cxs_pkg::QR_CB7) && half_q &&
		(dr_q == DR_W'(DOUBLE_ROUNDS - 1));

	// initial block state
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = cxs_pkg::SIGMA[i];
			init_w[4 + 2 * i] = key[i][31:0];
			init_w[5 + 2 * i] = key[i][63:32];
		end
		init_w[12] = counter_q[31:0];
		init_w[13] = counter_q[63:32];
		init_w[14] = nonce[31:0];
		init_w[15] = nonce[63:32];
	end

	// one step of four column quarter rounds in parallel
	always_comb begin
		nw = w_q;
		for (int j = 0; j < 4; j++) begin
			unique case (step_q)
				cxs_pkg::QR_AD16: begin
					nw[j]      = w_q[j] + w_q[4 + j];
					nw[12 + j] = cxs_pkg::rotl32(w_q[12 + j] ^ nw[j], 16);
				end
				cxs_pkg::QR_CB12: begin
					nw[8 + j]  = w_q[8 + j] + w_q[12 + j];
					nw[4 + j]  = cxs_pkg::rotl32(w_q[4 + j] ^ nw[8 + j], 12);
				end
				cxs_pkg::QR_AD8: begin
					nw[j]      = w_q[j] + w_q[4 + j];
					nw[12 + j] = cxs_pkg::rotl32(w_q[12 + j] ^ nw[j], 8);
				end
				cxs_pkg::QR_CB7: begin
					nw[8 + j]  = w_q[8 + j] + w_q[12 + j];
					nw[4 + j]  = cxs_pkg::rotl32(w_q[4 + j] ^ nw[8 + j], 7);
				end
				default: begin
					nw[j] = w_q[j];
				end
			endcase
		end
	end

	// at the end of a half round, rotate rows so diagonals line up as columns,
	// and rotate them back after the diagonal half
	always_comb begin
		pw = nw;
		if (step_q == cxs_pkg::QR_CB7) begin
			for (int j = 0; j < 4; j++) begin
				if (!half_q) begin
					pw[4 + j]  = nw[4 + ((j + 1) % 4)];
					pw[8 + j]  = nw[8 + ((j + 2) % 4)];
					pw[12 + j] = nw[12 + ((j + 3) % 4)];
				end else begin
					pw[4 + j]  = nw[4 + ((j + 3) % 4)];
					pw[8 + j]  = nw[8 + ((j + 2) % 4)];
					pw[12 + j] = nw[12 + ((j + 1) % 4)];
				end
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cxs_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d  = state_q;
		load_w   = 1'b0;
		round_en = 1'b0;
		feed_en  = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			cxs_pkg::BK_IDLE: begin
				if (head.valid) begin
					if (head.item.new_block) begin
						load_w  = 1'b1;
						state_d = cxs_pkg::BK_ROUND;
					end else if (out_free) begin
						emit = 1'b1;
					end
				end
			end
			cxs_pkg::BK_ROUND: begin
				round_en = 1'b1;
				if (last_step) begin
					state_d = cxs_pkg::BK_FEED;
				end
			end
			cxs_pkg::BK_FEED: begin
				feed_en = 1'b1;
				state_d = cxs_pkg::BK_EMIT;
			end
			cxs_pkg::BK_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = cxs_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = cxs_pkg::BK_IDLE;
			end
		endcase
	end

	// round counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cxs_pkg::QR_AD16;
			half_q <= 1'b0;
			dr_q   <= '0;
		end else if (load_w) begin
			step_q <= cxs_pkg::QR_AD16;
			half_q <= 1'b0;
			dr_q   <= '0;
		end else if (round_en) begin
			step_q <= cxs_pkg::cxs_qr_step_t'(step_q + 2'd1);
			if (step_q == cxs_pkg::QR_CB7) begin
				half_q <= !half_q;
				if (half_q) begin
					dr_q <= dr_q + 1'b1;
				end
			end
		end
	end

	// working state, which also holds the finished keystream block
	always_ff @(posedge clk) begin
		if (load_w) begin
			w_q <= init_w;
		end else if (round_en) begin
			w_q <= pw;
		end else if (feed_en) begin
			for (int i = 0; i < NW; i++) begin
				w_q[i] <= w_q[i] + init_w[i];
			end
		end
	end

	// advance the block counter per block, drop it at end of message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (emit && head.item.last) begin
			counter_q <= '0;
		end else if (feed_en) begin
			counter_q <= counter_q + 64'd1;
		end
	end

	// pick the keystream byte for this word
	assign ks_word = w_q[head.item.pos[5:2]];
	assign ks_byte = 8'(ks_word >> {head.item.pos[1:0], 3'b000});

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= head.item.data ^ ks_byte;
			out_last_q <= head.item.last;
		end
	end

	assign pop           = emit;
	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign out_last      = out_last_q;
	assign stat.emit     = emit;
	assign stat.ctr_zero = (counter_q == 64'd0);

endmodule
`default_nettype wire

>>> design/chacha20_stream_xor_unit.sv
// Path: an accepted word inside a block is queued, then goes through the output register; a word
//   at keystream position zero first waits for load, one quarter-round step per cycle
//   on four lanes, and the feed-forward add, and is then emitted.
// Throughput: 1 word per cycle within a 64-byte block while out_stall is low; each
//   new block holds the round unit for its rounds and feed-forward, while the input queue keeps filling.
// Reset: arst_n clears key, nonce, block counter, position, queue and output valid;
//   the keystream buffer is not cleared and is always rebuilt before use.
`default_nettype none
`include "chacha20_stream_xor_unit_macros.svh"
module chacha20_stream_xor_unit #(
	parameter int DOUBLE_ROUNDS = cxs_pkg::DOUBLE_ROUNDS_DEF,
	parameter int QUEUE_DEPTH   = cxs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             out_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [3:0][63:0]      key_q;
	logic [63:0]           nonce_q;
	logic                  cfg_we;
	logic                  pop;
	cxs_pkg::cxs_head_t    q_head;
	cxs_pkg::cxs_fr_stat_t fr_stat;
	cxs_pkg::cxs_bk_stat_t bk_stat;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_stall  = fr_stat.full;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cxs_pkg::CFG_KEY_LOW:   key_q[0] <= cfg_data;
				cxs_pkg::CFG_KEY_MID:   key_q[1] <= cfg_data;
				cxs_pkg::CFG_KEY_UPPER: key_q[2] <= cfg_data;
				cxs_pkg::CFG_KEY_TOP:   key_q[3] <= cfg_data;
				cxs_pkg::CFG_NONCE:     nonce_q  <= cfg_data;
				default:                nonce_q  <= nonce_q;
			endcase
		end
	end

	cxs_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.pop       (pop),
		.head      (q_head),
		.stat      (fr_stat)
	);

	cxs_back #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.key       (key_q),
		.nonce     (nonce_q),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.stat      (bk_stat)
	);

	// back end never takes a word from an empty queue
	`CXS_ASSERT_IMPL(a_pop_nonempty, bk_stat.emit, q_head.valid, "pop from empty queue")
	// a last word returns the block counter to zero
	`CXS_ASSERT_NEXT(a_last_clears_ctr, bk_stat.emit && q_head.item.last, bk_stat.ctr_zero, "counter not cleared after last word")
	// a last word returns the position to zero
	`CXS_ASSERT_NEXT(a_last_clears_pos, in_valid && !in_stall && last_byte, fr_stat.pos_zero, "position not cleared after last word")

endmodule
`default_nettype wire
